@@ src/sst_pkg.sv @@
`default_nettype none
package sst_pkg;

  localparam int OFF_W     = 24;
  localparam int LINE_W    = 16;
  localparam int COL_W     = 16;
  localparam int LEN_W     = 16;
  localparam int WBUF_D    = 8;
  localparam int WBUF_IW   = $clog2(WBUF_D);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [6:0] {
    K_EOF, K_ERROR, K_IDENT, K_STRING, K_NUMBER, K_INTEGER, K_HEXINT,
    K_AND, K_CLASS, K_ELSE, K_FALSE, K_FOR, K_FUN, K_IF, K_NIL, K_OR,
    K_PRINT, K_RETURN, K_SUPER, K_THIS, K_TRUE, K_VAR, K_WHILE, K_INF, K_NAN,
    K_COLON, K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_LSQ, K_RSQ, K_COMMA,
    K_DOT, K_SEMI, K_SIZE, K_BITNEG, K_MINUS, K_MINUS_EQ, K_PLUS, K_PLUS_EQ,
    K_AND_OP, K_AND_EQ, K_OR_OP, K_OR_EQ, K_XOR, K_XOR_EQ, K_SLASH,
    K_SLASH_EQ, K_REM, K_REM_EQ, K_BANG, K_BANG_EQ, K_EQ, K_EQ_EQ,
    K_STAR, K_STAR_EQ, K_STAR2, K_STAR2_EQ, K_GT, K_GE, K_SHR, K_SHR_EQ,
    K_LT, K_LE, K_SHL, K_SHL_EQ
  } kind_e;

  // byte under decision plus the two bytes after it; c == 0 marks end of source
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] w1;
    logic [7:0] w2;
  } cmd_t;

  typedef struct packed {
    logic [6:0]        kind;
    logic              cause;
    logic [OFF_W-1:0]  start_offset;
    logic [LEN_W-1:0]  length;
    logic [LINE_W-1:0] start_line;
    logic [COL_W-1:0]  start_column;
    logic [LINE_W-1:0] end_line;
    logic [COL_W-1:0]  end_column;
    logic              last;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // w holds the buffered word, first byte in the top bits
  function automatic kind_e kw_kind(input logic [LEN_W-1:0] len,
                                    input logic [8*WBUF_D-1:0] w);
    kind_e k;
    k = K_IDENT;
    case (len)
      LEN_W'(2): begin
        if (w[63:48] == "or") k = K_OR;
        else if (w[63:48] == "if") k = K_IF;
      end
      LEN_W'(3): begin
        if (w[63:40] == "and") k = K_AND;
        else if (w[63:40] == "var") k = K_VAR;
        else if (w[63:40] == "inf") k = K_INF;
        else if (w[63:40] == "NaN") k = K_NAN;
        else if (w[63:40] == "nil") k = K_NIL;
        else if (w[63:40] == "nan") k = K_NAN;
        else if (w[63:40] == "for") k = K_FOR;
        else if (w[63:40] == "fun") k = K_FUN;
      end
      LEN_W'(4): begin
        if (w[63:32] == "else") k = K_ELSE;
        else if (w[63:32] == "this") k = K_THIS;
        else if (w[63:32] == "true") k = K_TRUE;
      end
      LEN_W'(5): begin
        if (w[63:24] == "class") k = K_CLASS;
        else if (w[63:24] == "print") k = K_PRINT;
        else if (w[63:24] == "super") k = K_SUPER;
        else if (w[63:24] == "while") k = K_WHILE;
        else if (w[63:24] == "false") k = K_FALSE;
      end
      LEN_W'(6): begin
        if (w[63:16] == "return") k = K_RETURN;
      end
      LEN_W'(8): begin
        if (w == "Infinity") k = K_INF;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ src/sst_cmd_q.sv @@
`default_nettype none
module sst_cmd_q import sst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ src/sst_tok_q.sv @@
`default_nettype none
module sst_tok_q import sst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire tok_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output tok_t      data_o
);

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ src/sst_front.sv @@
`default_nettype none
module sst_front import sst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] byte_i,
  output logic            full_o,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output cmd_t            q_data_o
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } fstate_e;

  fstate_e    st_q, st_d;
  logic [7:0] w0_q, w0_d, w1_q, w1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc;

  assign full_o = (st_q == ST_FLUSH) || q_full_i;
  assign acc    = push_i && !full_o;

  always_comb begin
    st_d     = st_q;
    w0_d     = w0_q;
    w1_d     = w1_q;
    cnt_d    = cnt_q;
    q_push_o = 1'b0;
    q_data_o = '{c: w0_q, w1: w1_q, w2: byte_i};
    case (st_q)
      ST_RUN: begin
        if (acc) begin
          if (byte_i == CH_NUL) begin
            st_d = ST_FLUSH;
          end else if (cnt_q == 2'd2) begin
            q_push_o = 1'b1;
            w0_d     = w1_q;
            w1_d     = byte_i;
          end else if (cnt_q == 2'd1) begin
            w1_d  = byte_i;
            cnt_d = 2'd2;
          end else begin
            w0_d  = byte_i;
            cnt_d = 2'd1;
          end
        end
      end
      ST_FLUSH: begin
        // drain the window, then hand over the end-of-source word
        if (!q_full_i) begin
          q_push_o = 1'b1;
          if (cnt_q == 2'd2) begin
            q_data_o = '{c: w0_q, w1: w1_q, w2: CH_NUL};
            w0_d     = w1_q;
            cnt_d    = 2'd1;
          end else if (cnt_q == 2'd1) begin
            q_data_o = '{c: w0_q, w1: CH_NUL, w2: CH_NUL};
            cnt_d    = 2'd0;
          end else begin
            q_data_o = '{c: CH_NUL, w1: CH_NUL, w2: CH_NUL};
            st_d     = ST_RUN;
          end
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_RUN;
      cnt_q <= 2'd0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= w0_d;
    w1_q <= w1_d;
  end

endmodule
`default_nettype wire

@@ src/sst_back.sv @@
`default_nettype none
module sst_back import sst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic tok_full_i,
  output logic      tok_push_o,
  output tok_t      tok_o
);

  typedef enum logic [15:0] {
    M_IDLE        = 16'h0001,
    M_LINE        = 16'h0002,
    M_BLOCK       = 16'h0004,
    M_BLOCK_CLOSE = 16'h0008,
    M_IDENT       = 16'h0010,
    M_HEX_X       = 16'h0020,
    M_HEX_DIG     = 16'h0040,
    M_NUM         = 16'h0080,
    M_STR         = 16'h0100,
    M_OP_EQ       = 16'h0200,
    M_STAR1       = 16'h0400,
    M_STAR2       = 16'h0800,
    M_GT1         = 16'h1000,
    M_GT2         = 16'h2000,
    M_LT1         = 16'h4000,
    M_LT2         = 16'h8000
  } mode_e;

  localparam logic [OFF_W-1:0]  OFF_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  mode_e             mode_q, mode_d;
  logic [OFF_W-1:0]  ts_off_q, ts_off_d, cur_off_q, cur_off_d;
  logic [LINE_W-1:0] ts_line_q, ts_line_d, cur_line_q, cur_line_d;
  logic [COL_W-1:0]  ts_col_q, ts_col_d, cur_col_q, cur_col_d;
  logic [LEN_W-1:0]  len_q, len_d, len_base;
  logic              quote_q, quote_d, esc_q, esc_d, float_q, float_d;
  logic              skip_q, skip_d, armed_q, armed_d;
  logic [6:0]        pend_q, pend_d;
  logic [7:0]        wbuf_q [WBUF_D];
  logic [8*WBUF_D-1:0] wbuf_flat;

  logic [7:0]         c, w1, w2;
  logic               step, consumed, emit, ecause, elast, start, cons;
  logic               ws, line_c, block_c, eof;
  logic [6:0]         ekind;
  logic               wr_en;
  logic [WBUF_IW-1:0] wr_idx;

  assign c  = cmd_i.c;
  assign w1 = cmd_i.w1;
  assign w2 = cmd_i.w2;
  assign step = cmd_valid_i && !tok_full_i;

  always_comb begin
    for (int i = 0; i < WBUF_D; i++) begin
      wbuf_flat[8*(WBUF_D-1-i) +: 8] = wbuf_q[i];
    end
  end

  always_comb begin
    mode_d   = mode_q;
    consumed = 1'b0;
    emit     = 1'b0;
    ekind    = K_EOF;
    ecause   = 1'b0;
    elast    = 1'b0;
    start    = 1'b0;
    cons     = 1'b0;
    quote_d  = quote_q;
    esc_d    = esc_q;
    float_d  = float_q;
    skip_d   = skip_q;
    armed_d  = armed_q;
    pend_d   = pend_q;
    wr_en    = 1'b0;
    wr_idx   = '0;
    ws       = 1'b0;
    line_c   = 1'b0;
    block_c  = 1'b0;
    case (mode_q)
      M_IDLE: begin
        ws = c == " " || c == CH_TAB || c == CH_CR || c == CH_LF ||
             (c == ";" && skip_q);
        line_c  = (c == "#" && w1 == "!") || (c == "/" && w1 == "/");
        block_c = c == "/" && w1 == "*";
        if (!ws && !line_c && !block_c && armed_q) begin
          armed_d = 1'b0;
          // three semicolons right after a semicolon token open a skip run
          if (c == ";" && w1 == ";" && w2 == ";") begin
            skip_d = 1'b1;
            ws     = 1'b1;
          end
        end
        if (ws || line_c || block_c) begin
          cons     = 1'b1;
          consumed = 1'b1;
          mode_d   = line_c ? M_LINE : (block_c ? M_BLOCK : M_IDLE);
        end else begin
          skip_d = 1'b0;
          start  = 1'b1;
          if (c == CH_NUL) begin
            emit  = 1'b1;
            ekind = K_EOF;
            elast = 1'b1;
          end else begin
            cons     = 1'b1;
            consumed = 1'b1;
            if (is_alpha(c)) begin
              wr_en  = 1'b1;
              mode_d = M_IDENT;
            end else if (c == "0" && (w1 == "x" || w1 == "X")) begin
              mode_d = M_HEX_X;
            end else if (is_digit(c) || (c == "." && is_digit(w1))) begin
              float_d = 1'b0;
              mode_d  = M_NUM;
            end else begin
              case (c)
                ":": begin emit = 1'b1; ekind = K_COLON; end
                "(": begin emit = 1'b1; ekind = K_LPAREN; end
                ")": begin emit = 1'b1; ekind = K_RPAREN; end
                "{": begin emit = 1'b1; ekind = K_LBRACE; end
                "}": begin emit = 1'b1; ekind = K_RBRACE; end
                "[": begin emit = 1'b1; ekind = K_LSQ; end
                "]": begin emit = 1'b1; ekind = K_RSQ; end
                ",": begin emit = 1'b1; ekind = K_COMMA; end
                ".": begin emit = 1'b1; ekind = K_DOT; end
                ";": begin emit = 1'b1; ekind = K_SEMI; armed_d = 1'b1; end
                "#": begin emit = 1'b1; ekind = K_SIZE; end
                "~": begin emit = 1'b1; ekind = K_BITNEG; end
                "-": begin pend_d = K_MINUS; mode_d = M_OP_EQ; end
                "+": begin pend_d = K_PLUS; mode_d = M_OP_EQ; end
                "&": begin pend_d = K_AND_OP; mode_d = M_OP_EQ; end
                "|": begin pend_d = K_OR_OP; mode_d = M_OP_EQ; end
                "^": begin pend_d = K_XOR; mode_d = M_OP_EQ; end
                "/": begin pend_d = K_SLASH; mode_d = M_OP_EQ; end
                "%": begin pend_d = K_REM; mode_d = M_OP_EQ; end
                "!": begin pend_d = K_BANG; mode_d = M_OP_EQ; end
                "=": begin pend_d = K_EQ; mode_d = M_OP_EQ; end
                "*": mode_d = M_STAR1;
                ">": mode_d = M_GT1;
                "<": mode_d = M_LT1;
                "\"", "'": begin
                  quote_d = c == "'";
                  esc_d   = 1'b0;
                  mode_d  = M_STR;
                end
                default: begin emit = 1'b1; ekind = K_ERROR; end
              endcase
            end
          end
        end
      end
      M_LINE: begin
        if (c == CH_LF || c == CH_NUL) begin
          mode_d = M_IDLE;
        end else begin
          cons     = 1'b1;
          consumed = 1'b1;
        end
      end
      M_BLOCK: begin
        if (c == CH_NUL) begin
          mode_d = M_IDLE;
        end else begin
          if (c == "*" && w1 == "/") mode_d = M_BLOCK_CLOSE;
          cons     = 1'b1;
          consumed = 1'b1;
        end
      end
      M_BLOCK_CLOSE, M_HEX_X: begin
        mode_d   = (mode_q == M_HEX_X) ? M_HEX_DIG : M_IDLE;
        cons     = c != CH_NUL;
        consumed = c != CH_NUL;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          cons     = 1'b1;
          consumed = 1'b1;
          if (len_q < LEN_W'(WBUF_D)) begin
            wr_en  = 1'b1;
            wr_idx = len_q[WBUF_IW-1:0];
          end
        end else begin
          emit   = 1'b1;
          ekind  = (len_q > LEN_W'(WBUF_D)) ? K_IDENT : kw_kind(len_q, wbuf_flat);
          mode_d = M_IDLE;
        end
      end
      M_HEX_DIG: begin
        if (is_hex(c)) begin
          cons     = 1'b1;
          consumed = 1'b1;
        end else begin
          emit   = 1'b1;
          ekind  = K_HEXINT;
          mode_d = M_IDLE;
        end
      end
      M_NUM: begin
        if (!float_q) begin
          if (is_digit(c)) begin
            cons     = 1'b1;
            consumed = 1'b1;
          end else if (c == "e" || c == "E" || c == "-" || c == ".") begin
            float_d  = 1'b1;
            cons     = 1'b1;
            consumed = 1'b1;
          end else begin
            emit   = 1'b1;
            ekind  = K_INTEGER;
            mode_d = M_IDLE;
          end
        end else if (is_digit(c) ||
                     ((c == "e" || c == "E") &&
                      (w1 == "-" || w1 == "+" || is_digit(w1))) ||
                     ((c == "-" || c == "+") && is_digit(w1))) begin
          cons     = 1'b1;
          consumed = 1'b1;
        end else begin
          emit   = 1'b1;
          ekind  = K_NUMBER;
          mode_d = M_IDLE;
        end
      end
      M_STR: begin
        if (c == CH_NUL) begin
          emit   = 1'b1;
          ekind  = K_ERROR;
          ecause = 1'b1;
          mode_d = M_IDLE;
        end else begin
          cons     = 1'b1;
          consumed = 1'b1;
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (c == (quote_q ? 8'("'") : 8'("\""))) begin
            emit   = 1'b1;
            ekind  = K_STRING;
            mode_d = M_IDLE;
          end else if (c == "\\") begin
            esc_d = 1'b1;
          end
        end
      end
      M_OP_EQ: begin
        emit   = 1'b1;
        mode_d = M_IDLE;
        if (c == "=") begin
          cons     = 1'b1;
          consumed = 1'b1;
          ekind    = pend_q + 7'd1;
        end else begin
          ekind = pend_q;
        end
      end
      M_STAR1: begin
        if (c == "*") begin
          cons     = 1'b1;
          consumed = 1'b1;
          mode_d   = M_STAR2;
        end else begin
          emit   = 1'b1;
          mode_d = M_IDLE;
          ekind  = K_STAR;
          if (c == "=") begin
            cons     = 1'b1;
            consumed = 1'b1;
            ekind    = K_STAR_EQ;
          end
        end
      end
      M_STAR2, M_GT2, M_LT2: begin
        emit   = 1'b1;
        mode_d = M_IDLE;
        cons   = c == "=";
        consumed = c == "=";
        if (mode_q == M_STAR2) ekind = (c == "=") ? K_STAR2_EQ : K_STAR2;
        else if (mode_q == M_GT2) ekind = (c == "=") ? K_SHR_EQ : K_SHR;
        else ekind = (c == "=") ? K_SHL_EQ : K_SHL;
      end
      M_GT1, M_LT1: begin
        if (c == "=") begin
          cons     = 1'b1;
          consumed = 1'b1;
          emit     = 1'b1;
          ekind    = (mode_q == M_GT1) ? K_GE : K_LE;
          mode_d   = M_IDLE;
        end else if (c == ((mode_q == M_GT1) ? 8'(">") : 8'("<"))) begin
          cons     = 1'b1;
          consumed = 1'b1;
          mode_d   = (mode_q == M_GT1) ? M_GT2 : M_LT2;
        end else begin
          emit   = 1'b1;
          ekind  = (mode_q == M_GT1) ? K_GT : K_LT;
          mode_d = M_IDLE;
        end
      end
      default: mode_d = M_IDLE;
    endcase
  end

  // position bookkeeping; token fields are taken after this step's updates
  always_comb begin
    ts_off_d  = start ? cur_off_q : ts_off_q;
    ts_line_d = start ? cur_line_q : ts_line_q;
    ts_col_d  = start ? cur_col_q : ts_col_q;
    len_base  = start ? '0 : len_q;
    len_d     = len_base;
    cur_off_d  = cur_off_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    if (cons) begin
      len_d     = (len_base == LEN_MAX) ? LEN_MAX : len_base + 1'b1;
      cur_off_d = (cur_off_q == OFF_MAX) ? OFF_MAX : cur_off_q + 1'b1;
      if (c == CH_LF) begin
        cur_line_d = (cur_line_q == LINE_MAX) ? LINE_MAX : cur_line_q + 1'b1;
        cur_col_d  = '0;
      end else begin
        cur_col_d = (cur_col_q == COL_MAX) ? COL_MAX : cur_col_q + 1'b1;
      end
    end
  end

  assign eof        = emit && elast;
  assign cmd_pop_o  = step && (consumed || eof);
  assign tok_push_o = step && emit;
  assign tok_o = '{kind: ekind, cause: ecause, start_offset: ts_off_d, length: len_d,
                   start_line: ts_line_d, start_column: ts_col_d,
                   end_line: cur_line_d, end_column: cur_col_d, last: elast};

  always_ff @(posedge clk_i) begin
    if (step && wr_en) wbuf_q[wr_idx] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      ts_off_q   <= '0;
      ts_line_q  <= LINE_W'(1);
      ts_col_q   <= '0;
      cur_off_q  <= '0;
      cur_line_q <= LINE_W'(1);
      cur_col_q  <= '0;
      len_q      <= '0;
      quote_q    <= 1'b0;
      esc_q      <= 1'b0;
      float_q    <= 1'b0;
      skip_q     <= 1'b0;
      armed_q    <= 1'b0;
      pend_q     <= K_EOF;
    end else if (step) begin
      if (eof) begin
        // end of source: back to the start-of-source state
        mode_q     <= M_IDLE;
        ts_off_q   <= '0;
        ts_line_q  <= LINE_W'(1);
        ts_col_q   <= '0;
        cur_off_q  <= '0;
        cur_line_q <= LINE_W'(1);
        cur_col_q  <= '0;
        len_q      <= '0;
        quote_q    <= 1'b0;
        esc_q      <= 1'b0;
        float_q    <= 1'b0;
        skip_q     <= 1'b0;
        armed_q    <= 1'b0;
        pend_q     <= K_EOF;
      end else begin
        mode_q     <= mode_d;
        ts_off_q   <= ts_off_d;
        ts_line_q  <= ts_line_d;
        ts_col_q   <= ts_col_d;
        cur_off_q  <= cur_off_d;
        cur_line_q <= cur_line_d;
        cur_col_q  <= cur_col_d;
        len_q      <= len_d;
        quote_q    <= quote_d;
        esc_q      <= esc_d;
        float_q    <= float_d;
        skip_q     <= skip_d;
        armed_q    <= armed_d;
        pend_q     <= pend_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_push_o |-> !tok_full_i) else $error("token pushed into full queue");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i) else $error("word popped from empty queue");
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && eof) |=> (mode_q == M_IDLE && cur_off_q == '0 && len_q == '0))
    else $error("state not cleared after end of source");
  a_eof_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit && elast) |-> (cmd_pop_o && c == CH_NUL))
    else $error("end token without end-of-source word");
`endif

endmodule
`default_nettype wire

@@ src/script_source_tokenizer.sv @@
`default_nettype none
// Each word, a deciding byte with its two lookahead bytes, is written into the scan queue;
// the scan engine decides on it and pushes the token into the token queue at the outputs.
// Throughput: one byte per cycle; a byte that ends a token or a line comment without
// belonging to it is scanned twice; a full scan queue stalls input and a full token queue
// stalls the scan engine. A zero byte holds the input while the lookahead drains.
// Reset (async, active low) empties both queues and the lookahead; no clearing pass.
module script_source_tokenizer import sst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  src_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [6:0]       token_kind_o,
  output logic             error_cause_o,
  output logic [OFF_W-1:0] start_offset_o,
  output logic [LEN_W-1:0] token_length_o,
  output logic [LINE_W-1:0] start_line_o,
  output logic [COL_W-1:0] start_column_o,
  output logic [LINE_W-1:0] end_line_o,
  output logic [COL_W-1:0] end_column_o,
  output logic             is_last_o
);

  cmd_t q_in, q_out;
  logic q_push, q_full, q_valid, q_pop;
  tok_t tok_in, tok_out;
  logic tok_push, tok_full;

  sst_front u_front (
    .clk_i, .rst_ni,
    .push_i   (push),
    .byte_i   (src_byte_i),
    .full_o   (full),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  sst_cmd_q u_cmd_q (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  sst_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .tok_full_i  (tok_full),
    .tok_push_o  (tok_push),
    .tok_o       (tok_in)
  );

  sst_tok_q u_tok_q (
    .clk_i, .rst_ni,
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (tok_out)
  );

  assign token_kind_o   = tok_out.kind;
  assign error_cause_o  = tok_out.cause;
  assign start_offset_o = tok_out.start_offset;
  assign token_length_o = tok_out.length;
  assign start_line_o   = tok_out.start_line;
  assign start_column_o = tok_out.start_column;
  assign end_line_o     = tok_out.end_line;
  assign end_column_o   = tok_out.end_column;
  assign is_last_o      = tok_out.last;

endmodule
`default_nettype wire
